/* rtl/swas_pkg.sv */
// Package for the sliding window anagram search block.
// Holds the action codes, sizing constants and shared types; depends on nothing.
`default_nettype none

package swas_pkg;

   // Sizing of the search.
   localparam int MAX_PATTERN  = 64;     // longest pattern, also the history depth
   localparam int ALPHABET     = 26;     // letters a through z
   localparam int MAX_POSITION = 65535;  // largest window start that is reported

   // Field widths of the two channels.
   localparam int ACTION_W = 2;
   localparam int LETTER_W = 5;
   localparam int START_W  = 16;

   // Derived widths. The history is addressed by the low position bits, so its
   // depth is a power of two.
   localparam int HIST_AW = $clog2(MAX_PATTERN);
   localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
   localparam int POS_W   = $clog2(MAX_POSITION + MAX_PATTERN + 2);

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [START_W-1:0]  start_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [HIST_AW-1:0]  hist_addr_type;

   // Action codes carried in the request.
   localparam action_type ACT_CLEAR   = 2'd0;
   localparam action_type ACT_PATTERN = 2'd1;
   localparam action_type ACT_TEXT    = 2'd2;
   localparam action_type ACT_UNUSED  = 2'd3;

endpackage

`default_nettype wire

/* rtl/swas_channels.sv */
// Valid/ready channel interfaces of the sliding window anagram search block.
// Depends on swas_pkg for the payload types.
`default_nettype none

interface swas_req_if
   import swas_pkg::*;
   ();
   logic       valid;
   logic       ready;
   action_type action;
   letter_type letter;

   modport source (output valid, output action, output letter, input ready);
   modport sink   (input valid, input action, input letter, output ready);
endinterface

interface swas_rsp_if
   import swas_pkg::*;
   ();
   logic      valid;
   logic      ready;
   start_type match_start;

   modport source (output valid, output match_start, input ready);
   modport sink   (input valid, input match_start, output ready);
endinterface

`default_nettype wire

/* rtl/sliding_window_anagram_search.sv */
// Sliding window anagram search, top level.
// Depends on swas_pkg and the channel interfaces in swas_channels.sv.
//
// Requests arrive on req_channel, one action and letter per transfer. A clear
// starts a new search, pattern letters build the per-letter pattern counts and
// set the window length (up to 64 letters), and text letters then stream
// through the window. Whenever the window holds a permutation of the pattern,
// one transfer on rsp_channel carries the zero-based start of that window.
//
// A request is finished in the cycle it is accepted and one can be accepted
// in every cycle unless a response is stalled. The response register loads at
// the accepting edge, so a response is offered in the next cycle. The cycle is
// set by one increment and one decrement of the window counts and the 26-way
// compare. The leaving letter comes from a 64-entry history memory read ahead;
// a bypass register covers the one-letter pattern, its slot written then read.
//
// Reset (synchronous, active high) clears the counts, position, pattern length
// and response valid; history entries are only read once written. While a
// response waits on a stalled receiver, req_channel.ready stays low.
`default_nettype none

module sliding_window_anagram_search
   import swas_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   swas_req_if.sink    req_channel,
   swas_rsp_if.source  rsp_channel
);

   localparam pos_type   MAX_POS_V  = POS_W'(MAX_POSITION);
   localparam count_type MAX_PAT_V  = CNT_W'(MAX_PATTERN);
   localparam letter_type ALPHA_V   = LETTER_W'(ALPHABET);

   // Search state.
   count_type pat_cnt_ff [ALPHABET];
   count_type pat_cnt_in [ALPHABET];
   count_type win_cnt_ff [ALPHABET];
   count_type win_cnt_in [ALPHABET];
   count_type plen_ff, plen_in;
   pos_type   pos_ff, pos_in;
   logic      started_ff, started_in;

   // History memory with a look-ahead read and a write bypass.
   letter_type    hist_ff [MAX_PATTERN];
   letter_type    rd_data_ff;
   logic          fwd_ff, fwd_in;
   letter_type    fwd_data_ff;
   hist_addr_type rd_addr, wr_addr;
   logic          hist_we;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in;
   start_type rsp_start_ff, rsp_start_in;

   logic       accept;
   action_type action;
   letter_type letter;
   logic       letter_ok;
   logic       do_clear, do_pattern, do_text_live, do_window, do_dec;
   letter_type gone;
   logic       gone_ok;
   pos_type    pos_inc, start_pos;
   logic [ALPHABET-1:0] eq_vec;
   logic       emit;

   assign action = req_channel.action;
   assign letter = req_channel.letter;

   // The output register frees up in the same cycle its response is taken.
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept            = req_channel.valid && req_channel.ready;

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.match_start = rsp_start_ff;

   // Decode of the accepted request. Pattern and text letters outside the
   // alphabet and the unused action code leave the state alone.
   assign letter_ok    = letter < ALPHA_V;
   assign do_clear     = accept && (action == ACT_CLEAR);
   assign do_pattern   = accept && (action == ACT_PATTERN) && letter_ok &&
                         !started_ff && (plen_ff < MAX_PAT_V);
   // Text letters stop counting once no later window could be reported.
   assign do_text_live = accept && (action == ACT_TEXT) && letter_ok &&
                         !(pos_ff > (MAX_POS_V + POS_W'(plen_ff)));
   assign do_window    = do_text_live && (plen_ff != '0);
   assign do_dec       = do_window && (pos_ff >= POS_W'(plen_ff));

   // Letter that leaves the window.
   assign gone    = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign gone_ok = gone < ALPHA_V;

   assign pos_inc   = pos_ff + POS_W'(1);
   assign start_pos = pos_inc - POS_W'(plen_ff);

   always_comb begin
      for (int k = 0; k < ALPHABET; k++) begin
         pat_cnt_in[k] = pat_cnt_ff[k];
         win_cnt_in[k] = win_cnt_ff[k];
         if (do_pattern && (letter == LETTER_W'(k))) begin
            pat_cnt_in[k] = pat_cnt_ff[k] + CNT_W'(1);
         end
         if (do_window) begin
            if (do_dec && gone_ok && (gone == LETTER_W'(k)) && (win_cnt_ff[k] != '0)) begin
               win_cnt_in[k] = win_cnt_in[k] - CNT_W'(1);
            end
            if (letter == LETTER_W'(k)) begin
               win_cnt_in[k] = win_cnt_in[k] + CNT_W'(1);
            end
         end
         eq_vec[k] = (win_cnt_in[k] == pat_cnt_ff[k]);
      end
   end

   // A window is reported once it is full, its start is in range and every
   // letter count agrees with the pattern.
   assign emit = do_window && (pos_inc >= POS_W'(plen_ff)) &&
                 (start_pos <= MAX_POS_V) && (&eq_vec);

   always_comb begin
      plen_in    = plen_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      if (do_pattern) begin
         plen_in = plen_ff + CNT_W'(1);
      end
      if (accept && (action == ACT_TEXT) && letter_ok) begin
         started_in = 1'b1;
      end
      if (do_text_live) begin
         pos_in = pos_inc;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_channel.ready);
   assign rsp_start_in = emit ? start_pos[START_W-1:0] : rsp_start_ff;

   // History write at the current position; the read address is the slot the
   // next text letter will drop, taken from the next position and length.
   assign hist_we = do_window;
   assign wr_addr = pos_ff[HIST_AW-1:0];
   assign rd_addr = (do_clear ? '0 : pos_in[HIST_AW-1:0]) -
                    (do_clear ? '0 : plen_in[HIST_AW-1:0]);
   assign fwd_in  = hist_we && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_ff[wr_addr] <= letter;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= hist_ff[rd_addr];
      fwd_data_ff <= letter;
      rsp_start_ff <= rsp_start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ALPHABET; k++) begin
            pat_cnt_ff[k] <= '0;
            win_cnt_ff[k] <= '0;
         end
         plen_ff      <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_clear) begin
            for (int k = 0; k < ALPHABET; k++) begin
               pat_cnt_ff[k] <= '0;
               win_cnt_ff[k] <= '0;
            end
            plen_ff    <= '0;
            pos_ff     <= '0;
            started_ff <= 1'b0;
         end else begin
            for (int k = 0; k < ALPHABET; k++) begin
               pat_cnt_ff[k] <= pat_cnt_in[k];
               win_cnt_ff[k] <= win_cnt_in[k];
            end
            plen_ff    <= plen_in;
            pos_ff     <= pos_in;
            started_ff <= started_in;
         end
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The pattern length never passes the history depth.
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= MAX_PAT_V)
      else $error("pattern length beyond history depth");

   // A clear leaves an empty search behind.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (plen_ff == '0) && (pos_ff == '0) && !started_ff)
      else $error("clear did not empty the search");

   // A new response only follows an accepted text letter.
   a_rsp_from_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_channel.ready)) |->
         $past(accept && (action == ACT_TEXT)))
      else $error("response without a text letter");

   // Pattern letters after the text has begun do not change the length.
   a_pattern_locked: assert property (@(posedge clock) disable iff (reset)
      (accept && (action == ACT_PATTERN) && started_ff) |=> $stable(plen_ff))
      else $error("pattern grew after text began");

endmodule

`default_nettype wire
